// File: rtl/incremental_pid_deadband_clamp_top_defines.svh
// Assertion macros for the checker file of the PID controller block.
`ifndef INCREMENTAL_PID_DEADBAND_CLAMP_TOP_DEFINES_SVH
`define INCREMENTAL_PID_DEADBAND_CLAMP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while rst is high.
`define IPDC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipdc assertion failed");

// Next-cycle implication, disabled while rst is high.
`define IPDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipdc assertion failed");

`endif

// File: rtl/ipdc_pkg.sv
// Shared types and constants of the incremental PID controller.
package ipdc_pkg;

   localparam int DATA_W    = 16;
   localparam int LIMIT_W   = 15;
   localparam int MCAND_W   = 18;
   localparam int ACC_W     = 20;
   localparam int PROD_W    = ACC_W + DATA_W;
   localparam int DIGIT_W   = 2;
   localparam int MUL_STEPS = DATA_W / DIGIT_W;
   localparam int STEP_W    = $clog2(MUL_STEPS);
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] IDX_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] IDX_DEAD_BAND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] IDX_OUT_LIMIT  = 3'd4;

   localparam logic signed [DATA_W-1:0] RST_PROP_GAIN  = 16'sd256;
   localparam logic signed [DATA_W-1:0] RST_INTEG_GAIN = 16'sd0;
   localparam logic signed [DATA_W-1:0] RST_DERIV_GAIN = 16'sd0;
   localparam logic [LIMIT_W-1:0]       RST_DEAD_BAND  = 15'd512;
   localparam logic [LIMIT_W-1:0]       RST_OUT_LIMIT  = 15'd20480;

   // smoothing weights, Q0.15
   localparam logic signed [MCAND_W-1:0] W_NEW = 18'sd29491;
   localparam logic signed [MCAND_W-1:0] W_OLD = 18'sd3277;

   typedef struct packed {
      logic signed [DATA_W-1:0] prop_gain;
      logic signed [DATA_W-1:0] integ_gain;
      logic signed [DATA_W-1:0] deriv_gain;
      logic [LIMIT_W-1:0]       dead_band;
      logic [LIMIT_W-1:0]       out_limit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic step;
   } mul_ctl_type;

endpackage

// File: rtl/ipdc_csr.sv
// Configuration register file of the PID controller.
module ipdc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [ipdc_pkg::CSR_IDX_W-1:0]      wr_index,
   input  logic [ipdc_pkg::DATA_W-1:0]         wr_data,
   output ipdc_pkg::cfg_type                   cfg
);

   ipdc_pkg::cfg_type cfg_ff;
   ipdc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            ipdc_pkg::IDX_PROP_GAIN:  cfg_in.prop_gain  = $signed(wr_data);
            ipdc_pkg::IDX_INTEG_GAIN: cfg_in.integ_gain = $signed(wr_data);
            ipdc_pkg::IDX_DERIV_GAIN: cfg_in.deriv_gain = $signed(wr_data);
            ipdc_pkg::IDX_DEAD_BAND:  cfg_in.dead_band  = wr_data[ipdc_pkg::LIMIT_W-1:0];
            ipdc_pkg::IDX_OUT_LIMIT:  cfg_in.out_limit  = wr_data[ipdc_pkg::LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain  <= ipdc_pkg::RST_PROP_GAIN;
         cfg_ff.integ_gain <= ipdc_pkg::RST_INTEG_GAIN;
         cfg_ff.deriv_gain <= ipdc_pkg::RST_DERIV_GAIN;
         cfg_ff.dead_band  <= ipdc_pkg::RST_DEAD_BAND;
         cfg_ff.out_limit  <= ipdc_pkg::RST_OUT_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/ipdc_mul.sv
// Radix-4 Booth digit-serial multiplier lane: two multiplier bits per step.
module ipdc_mul (
   input  logic                                      clock,
   input  ipdc_pkg::mul_ctl_type                     ctl,
   input  logic signed [ipdc_pkg::MCAND_W-1:0]       mcand,
   input  logic signed [ipdc_pkg::DATA_W-1:0]        mplier,
   output logic signed [ipdc_pkg::PROD_W-1:0]        prod
);

   localparam int SUM_W = ipdc_pkg::ACC_W + 1;

   logic signed [ipdc_pkg::MCAND_W-1:0] a_ff;
   logic signed [ipdc_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic [ipdc_pkg::DATA_W-1:0]         bq_ff, bq_in;
   logic                                bprev_ff, bprev_in;

   logic                    neg, one_a, two_a;
   logic [SUM_W-1:0]        pp_mag, a_ext, sum;

   always_comb begin
      // Booth digit from bits {b1, b0, b-1}
      neg    = bq_ff[1];
      one_a  = bq_ff[0] ^ bprev_ff;
      two_a  = (bq_ff[1] & ~bq_ff[0] & ~bprev_ff) | (~bq_ff[1] & bq_ff[0] & bprev_ff);
      a_ext  = SUM_W'(a_ff);
      a_ext  = {{(SUM_W-ipdc_pkg::MCAND_W){a_ff[ipdc_pkg::MCAND_W-1]}}, a_ff};
      pp_mag = two_a ? {a_ext[SUM_W-2:0], 1'b0} : (one_a ? a_ext : '0);
      sum    = {acc_ff[ipdc_pkg::ACC_W-1], acc_ff} + (pp_mag ^ {SUM_W{neg}})
               + SUM_W'(neg);
      acc_in   = {sum[SUM_W-1], sum[SUM_W-1:ipdc_pkg::DIGIT_W]};
      bq_in    = {sum[ipdc_pkg::DIGIT_W-1:0], bq_ff[ipdc_pkg::DATA_W-1:ipdc_pkg::DIGIT_W]};
      bprev_in = bq_ff[1];
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         a_ff     <= mcand;
         acc_ff   <= '0;
         bq_ff    <= mplier;
         bprev_ff <= 1'b0;
      end else if (ctl.step) begin
         acc_ff   <= acc_in;
         bq_ff    <= bq_in;
         bprev_ff <= bprev_in;
      end
   end

   // low word holds the product bits shifted out so far
   assign prod = {acc_ff, bq_ff};

endmodule

// File: rtl/incremental_pid_deadband_clamp_top.sv
// Incremental PID controller with input smoothing, dead band and drive clamp.
//
// Input channel req_*: one Q8.8 error word per control tick, taken when
// req_valid and req_ready are high at a clock edge. Result channel rsp_*:
// the clamped drive word and the clamped flag. Configuration channel csr_*:
// csr_index selects prop_gain, integ_gain, deriv_gain, dead_band, out_limit
// (0 to 4, others ignored); csr_ready is always high. Write only when idle.
//
// A word runs two passes through three Booth radix-4 multiplier lanes (8 steps
// each, smoothing then gain products) plus add, dead band, load and clamp
// steps. A new word is taken only after the last one leaves the clamp step,
// as req_ready is high only when idle.
//
// A finished result sits in the output register while the next word is
// taken. If the receiver stalls, the next result waits in the clamp step
// until the output register frees.
//
// Reset (synchronous, active high) clears the held error, increment and
// drive, loads register defaults and empties the output register.
module incremental_pid_deadband_clamp_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [ipdc_pkg::DATA_W-1:0]   req_error_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ipdc_pkg::DATA_W-1:0]   rsp_drive,
   output logic                                 rsp_clamped,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ipdc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ipdc_pkg::DATA_W-1:0]          csr_data
);

   localparam int ST_W  = 4;
   localparam int PSH_W = ipdc_pkg::PROD_W - 8;
   localparam int T_W   = PSH_W + 1;
   localparam int DRV_W = T_W + 1;
   localparam int FS_W  = ipdc_pkg::PROD_W + 1;
   localparam int INC_W = ipdc_pkg::DATA_W + 1;

   localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [ST_W-1:0] ST_MUL1  = 4'd1;
   localparam logic [ST_W-1:0] ST_FSUM  = 4'd2;
   localparam logic [ST_W-1:0] ST_FDB   = 4'd3;
   localparam logic [ST_W-1:0] ST_FINC  = 4'd4;
   localparam logic [ST_W-1:0] ST_FLOAD = 4'd5;
   localparam logic [ST_W-1:0] ST_MUL2  = 4'd6;
   localparam logic [ST_W-1:0] ST_SUMA  = 4'd7;
   localparam logic [ST_W-1:0] ST_SUMB  = 4'd8;
   localparam logic [ST_W-1:0] ST_CLAMP = 4'd9;

   ipdc_pkg::cfg_type cfg;

   logic [ST_W-1:0]                    state_ff, state_in;
   logic [ipdc_pkg::STEP_W-1:0]        cnt_ff, cnt_in;

   logic signed [ipdc_pkg::DATA_W-1:0] held_error_ff, held_error_in;
   logic signed [INC_W-1:0]            held_inc_ff, held_inc_in;
   logic signed [ipdc_pkg::DATA_W-1:0] held_drive_ff, held_drive_in;

   logic signed [ipdc_pkg::DATA_W-1:0] s_raw_ff, s_raw_in;
   logic signed [ipdc_pkg::DATA_W-1:0] s_ff, s_in;
   logic signed [INC_W-1:0]            inc_ff, inc_in;
   logic signed [T_W-1:0]              t01_ff, t01_in, t2d_ff, t2d_in;
   logic signed [DRV_W-1:0]            drv_ff, drv_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [ipdc_pkg::DATA_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic                               rsp_clamped_ff, rsp_clamped_in;

   ipdc_pkg::mul_ctl_type                       mctl;
   logic signed [ipdc_pkg::MCAND_W-1:0]         mcand0, mcand1, mcand2;
   logic signed [ipdc_pkg::DATA_W-1:0]          mplier0, mplier1, mplier2;
   logic signed [ipdc_pkg::PROD_W-1:0]          prod0, prod1, prod2;

   logic                                        req_take, out_free, in_band;
   logic signed [FS_W-1:0]                      filt_sum;
   logic signed [INC_W-1:0]                     s17, db17;
   logic signed [ipdc_pkg::MCAND_W-1:0]         dd;
   logic signed [DRV_W-1:0]                     lim, neg_lim;

   ipdc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   ipdc_mul u_mul0 (
      .clock (clock), .ctl (mctl), .mcand (mcand0), .mplier (mplier0), .prod (prod0)
   );
   ipdc_mul u_mul1 (
      .clock (clock), .ctl (mctl), .mcand (mcand1), .mplier (mplier1), .prod (prod1)
   );
   ipdc_mul u_mul2 (
      .clock (clock), .ctl (mctl), .mcand (mcand2), .mplier (mplier2), .prod (prod2)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // lane operands: smoothing pass from the input port and held error, gain pass from registers
   always_comb begin
      dd = {inc_ff[INC_W-1], inc_ff} - {held_inc_ff[INC_W-1], held_inc_ff};
      mctl.load = req_take || (state_ff == ST_FLOAD);
      mctl.step = (state_ff == ST_MUL1) || (state_ff == ST_MUL2);
      if (state_ff == ST_FLOAD) begin
         mcand0  = {inc_ff[INC_W-1], inc_ff};
         mcand1  = {{(ipdc_pkg::MCAND_W-ipdc_pkg::DATA_W){s_ff[ipdc_pkg::DATA_W-1]}}, s_ff};
         mcand2  = dd;
         mplier0 = cfg.prop_gain;
         mplier1 = cfg.integ_gain;
         mplier2 = cfg.deriv_gain;
      end else begin
         mcand0  = ipdc_pkg::W_NEW;
         mcand1  = ipdc_pkg::W_OLD;
         mcand2  = '0;
         mplier0 = req_error_sample;
         mplier1 = held_error_ff;
         mplier2 = '0;
      end
   end

   always_comb begin
      filt_sum = {prod0[ipdc_pkg::PROD_W-1], prod0} + {prod1[ipdc_pkg::PROD_W-1], prod1};
      s_raw_in = filt_sum[30:15];

      s17     = {s_raw_ff[ipdc_pkg::DATA_W-1], s_raw_ff};
      db17    = $signed({2'b00, cfg.dead_band});
      in_band = (s17 < db17) && (s17 > -db17);
      s_in    = in_band ? '0 : s_raw_ff;

      inc_in = {s_ff[ipdc_pkg::DATA_W-1], s_ff}
               - {held_error_ff[ipdc_pkg::DATA_W-1], held_error_ff};

      // each product floored by 2^8 on its own
      t01_in = {prod0[ipdc_pkg::PROD_W-1], prod0[ipdc_pkg::PROD_W-1:8]}
               + {prod1[ipdc_pkg::PROD_W-1], prod1[ipdc_pkg::PROD_W-1:8]};
      t2d_in = {prod2[ipdc_pkg::PROD_W-1], prod2[ipdc_pkg::PROD_W-1:8]}
               + {{(T_W-ipdc_pkg::DATA_W){held_drive_ff[ipdc_pkg::DATA_W-1]}},
                  held_drive_ff};
      drv_in = {t01_ff[T_W-1], t01_ff} + {t2d_ff[T_W-1], t2d_ff};

      lim     = $signed({{(DRV_W-ipdc_pkg::LIMIT_W){1'b0}}, cfg.out_limit});
      neg_lim = -lim;
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      held_error_in  = held_error_ff;
      held_inc_in    = held_inc_ff;
      held_drive_in  = held_drive_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_clamped_in = rsp_clamped_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_MUL1;
               cnt_in   = '0;
            end
         end
         ST_MUL1: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ipdc_pkg::STEP_W'(ipdc_pkg::MUL_STEPS - 1)) begin
               state_in = ST_FSUM;
            end
         end
         ST_FSUM:  state_in = ST_FDB;
         ST_FDB:   state_in = ST_FINC;
         ST_FINC:  state_in = ST_FLOAD;
         ST_FLOAD: begin
            state_in = ST_MUL2;
            cnt_in   = '0;
         end
         ST_MUL2: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ipdc_pkg::STEP_W'(ipdc_pkg::MUL_STEPS - 1)) begin
               state_in = ST_SUMA;
            end
         end
         ST_SUMA: state_in = ST_SUMB;
         ST_SUMB: state_in = ST_CLAMP;
         ST_CLAMP: begin
            if (out_free) begin
               if (drv_ff > lim) begin
                  held_drive_in  = lim[ipdc_pkg::DATA_W-1:0];
                  rsp_clamped_in = 1'b1;
               end else if (drv_ff < neg_lim) begin
                  held_drive_in  = neg_lim[ipdc_pkg::DATA_W-1:0];
                  rsp_clamped_in = 1'b1;
               end else begin
                  held_drive_in  = drv_ff[ipdc_pkg::DATA_W-1:0];
                  rsp_clamped_in = 1'b0;
               end
               rsp_drive_in  = held_drive_in;
               rsp_valid_in  = 1'b1;
               held_error_in = s_ff;
               held_inc_in   = inc_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         held_error_ff <= '0;
         held_inc_ff   <= '0;
         held_drive_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         held_error_ff <= held_error_in;
         held_inc_ff   <= held_inc_in;
         held_drive_ff <= held_drive_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_drive_ff   <= rsp_drive_in;
      rsp_clamped_ff <= rsp_clamped_in;
      if (state_ff == ST_FSUM) s_raw_ff <= s_raw_in;
      if (state_ff == ST_FDB)  s_ff     <= s_in;
      if (state_ff == ST_FINC) inc_ff   <= inc_in;
      if (state_ff == ST_SUMA) begin
         t01_ff <= t01_in;
         t2d_ff <= t2d_in;
      end
      if (state_ff == ST_SUMB) drv_ff <= drv_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_drive   = rsp_drive_ff;
   assign rsp_clamped = rsp_clamped_ff;

endmodule

// File: rtl/ipdc_chk.sv
// Port-level checks of the PID controller top level, bound to it.
`include "incremental_pid_deadband_clamp_top_defines.svh"

module ipdc_chk (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [ipdc_pkg::DATA_W-1:0]   rsp_drive,
   input logic                                 rsp_clamped
);

   logic                        rsp_stall;
   logic [ipdc_pkg::DATA_W:0]   rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_drive, rsp_clamped};

   // a stalled result word holds
   `IPDC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // one word in flight: busy right after a word is taken
   `IPDC_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready, !req_ready)

   // clamp keeps the drive inside the symmetric range
   `IPDC_ASSERT_IMPL(a_drive_range, clock, reset, rsp_valid, rsp_drive != 16'sh8000)

   // out of reset: empty output, ready for input
   `IPDC_ASSERT_IMPL(a_reset_state, clock, 1'b0, $fell(reset), !rsp_valid && req_ready)

endmodule

bind incremental_pid_deadband_clamp_top ipdc_chk u_ipdc_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_drive        (rsp_drive),
   .rsp_clamped      (rsp_clamped)
);

// File: test/tb.sv
// Self-checking testbench for the incremental PID controller with dead band and drive clamp.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES  = 9;
   localparam int SETTLE_CYCLES = 32;
   localparam int IDLE_PCT      = 35;
   localparam int MAX_SHOWN     = 10;
   localparam int STALL_CYCLES  = 400;
   localparam int PHASE_WORDS   = 90;
   // ~850 words plus drains stay well under this limit
   localparam int CYCLE_LIMIT   = 400000;

   localparam logic [ipdc_pkg::CSR_IDX_W-1:0] IDX_FIRST_UNMAPPED =
      ipdc_pkg::IDX_OUT_LIMIT + 3'd1;
   localparam logic [ipdc_pkg::CSR_IDX_W-1:0] IDX_LAST_UNMAPPED  = '1;

   localparam longint FILTER_NEW = 29491;
   localparam longint FILTER_OLD = 3277;

   localparam logic [ipdc_pkg::DATA_W-1:0] GAIN_MAX  = 16'h7FFF;
   localparam logic [ipdc_pkg::DATA_W-1:0] GAIN_MIN  = 16'h8000;
   localparam logic [ipdc_pkg::DATA_W-1:0] FIELD_MAX = 16'h7FFF;
   localparam logic [ipdc_pkg::DATA_W-1:0] TOP_BIT   = 16'h8000;

   typedef enum int {CFG_FLOOR, CFG_CEILING, CFG_TYPICAL, CFG_ANY} cfg_mode_type;

   typedef struct packed {
      logic signed [ipdc_pkg::DATA_W-1:0] drive;
      logic                               clamped;
   } drive_word_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [ipdc_pkg::DATA_W-1:0] req_error_sample = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [ipdc_pkg::DATA_W-1:0] rsp_drive;
   logic                               rsp_clamped;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [ipdc_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [ipdc_pkg::DATA_W-1:0]        csr_data = '0;

   // controller model state
   ipdc_pkg::cfg_type                  ctl_cfg;
   logic signed [ipdc_pkg::DATA_W-1:0] held_err;
   logic signed [ipdc_pkg::DATA_W:0]   held_inc;
   logic signed [ipdc_pkg::DATA_W-1:0] held_drv;
   drive_word_type                     drive_expect_q[$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  stall_request = 0;
   int  stall_left = 0;
   int  walk_err = 0;
   bit  steady = 1'b0;

   incremental_pid_deadband_clamp_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_error_sample (req_error_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive        (rsp_drive),
      .rsp_clamped      (rsp_clamped),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("incremental_pid_deadband_clamp_top regression: fail");
      $finish;
   end

   // smoothed error before the dead band, floor of the weighted sum
   function automatic longint smooth_error(
      input logic signed [ipdc_pkg::DATA_W-1:0] sample);
      return (FILTER_NEW * longint'(sample) + FILTER_OLD * longint'(held_err)) >>> 15;
   endfunction

   function automatic void predict_drive(input logic signed [ipdc_pkg::DATA_W-1:0] sample);
      longint s, mag, inc, dd, sum, drv, lim;
      drive_word_type word;
      s = smooth_error(sample);
      mag = (s < 0) ? -s : s;
      if (mag < longint'(ctl_cfg.dead_band)) s = 0;
      inc = s - longint'(held_err);
      dd  = inc - longint'(held_inc);
      sum = ((longint'($signed(ctl_cfg.prop_gain)) * inc) >>> 8)
          + ((longint'($signed(ctl_cfg.integ_gain)) * s) >>> 8)
          + ((longint'($signed(ctl_cfg.deriv_gain)) * dd) >>> 8);
      drv = longint'(held_drv) + sum;
      lim = longint'(ctl_cfg.out_limit);
      word.clamped = 1'b0;
      if (drv > lim) begin
         drv = lim;
         word.clamped = 1'b1;
      end else if (drv < -lim) begin
         drv = -lim;
         word.clamped = 1'b1;
      end
      held_drv = drv[ipdc_pkg::DATA_W-1:0];
      held_err = s[ipdc_pkg::DATA_W-1:0];
      held_inc = inc[ipdc_pkg::DATA_W:0];
      word.drive = drv[ipdc_pkg::DATA_W-1:0];
      drive_expect_q.push_back(word);
   endfunction

   function automatic void apply_register(input logic [ipdc_pkg::CSR_IDX_W-1:0] idx,
                                          input logic [ipdc_pkg::DATA_W-1:0] value);
      case (idx)
         ipdc_pkg::IDX_PROP_GAIN:  ctl_cfg.prop_gain = value;
         ipdc_pkg::IDX_INTEG_GAIN: ctl_cfg.integ_gain = value;
         ipdc_pkg::IDX_DERIV_GAIN: ctl_cfg.deriv_gain = value;
         ipdc_pkg::IDX_DEAD_BAND:  ctl_cfg.dead_band = value[ipdc_pkg::LIMIT_W-1:0];
         ipdc_pkg::IDX_OUT_LIMIT:  ctl_cfg.out_limit = value[ipdc_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic logic [ipdc_pkg::DATA_W-1:0] rand_centered(input int span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - span;
      return v[ipdc_pkg::DATA_W-1:0];
   endfunction

   function automatic logic signed [ipdc_pkg::DATA_W-1:0] next_sample();
      int pick;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         // slowly drifting error, the usual shape of a steering loop
         walk_err = walk_err + int'($urandom_range(0, 1024)) - 512;
         if (walk_err > 16384) walk_err = 16384;
         if (walk_err < -16384) walk_err = -16384;
         v = walk_err;
      end else if (pick < 75) begin
         v = $urandom();
      end else begin
         v = int'($urandom_range(0, 2047)) - 1024;
      end
      return v[ipdc_pkg::DATA_W-1:0];
   endfunction

   task automatic send_sample(input logic signed [ipdc_pkg::DATA_W-1:0] sample);
      if (!steady) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_error_sample <= sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_drive(sample);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ipdc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ipdc_pkg::DATA_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_register(idx, value);
      csr_valid <= 1'b0;
   endtask

   task automatic program_phase(input cfg_mode_type mode);
      logic [ipdc_pkg::DATA_W-1:0] pg, ig, dg, band, lim;
      case (mode)
         CFG_FLOOR: begin
            pg = GAIN_MIN;
            ig = GAIN_MIN;
            dg = GAIN_MIN;
            band = '0;
            lim = FIELD_MAX;
         end
         CFG_CEILING: begin
            pg = GAIN_MAX;
            ig = GAIN_MAX;
            dg = GAIN_MAX;
            band = '0;
            lim = FIELD_MAX;
         end
         CFG_TYPICAL: begin
            pg = rand_centered(1024);
            ig = rand_centered(128);
            dg = rand_centered(512);
            band = ipdc_pkg::DATA_W'($urandom_range(0, 1024));
            lim = ipdc_pkg::DATA_W'($urandom_range(256, 32767));
         end
         default: begin
            pg = ipdc_pkg::DATA_W'($urandom());
            ig = ipdc_pkg::DATA_W'($urandom());
            dg = ipdc_pkg::DATA_W'($urandom());
            band = ipdc_pkg::DATA_W'($urandom_range(0, 4095))
                   | (($urandom() & 1) ? TOP_BIT : '0);
            lim = ipdc_pkg::DATA_W'($urandom());
         end
      endcase
      write_reg(ipdc_pkg::IDX_PROP_GAIN, pg);
      write_reg(ipdc_pkg::IDX_INTEG_GAIN, ig);
      write_reg(ipdc_pkg::IDX_DERIV_GAIN, dg);
      write_reg(ipdc_pkg::IDX_DEAD_BAND, band);
      write_reg(ipdc_pkg::IDX_OUT_LIMIT, lim);
      write_reg(ipdc_pkg::CSR_IDX_W'($urandom_range(IDX_FIRST_UNMAPPED, IDX_LAST_UNMAPPED)),
                ipdc_pkg::DATA_W'($urandom()));
   endtask

   task automatic test_defaults();
      send_sample(16'sd0);
      send_sample(16'sd256);      // smooths below the default band
      send_sample(-16'sd4096);
      send_sample(16'sd4096);
      send_sample(16'sh7FFF);     // drive runs into the default limit
      send_sample(16'sh8000);
   endtask

   task automatic test_dead_band_edge();
      longint s;
      longint band;
      // magnitude equal to the band passes, one below it is zeroed
      s = smooth_error(16'sd1500);
      band = (s < 0) ? -s : s;
      write_reg(ipdc_pkg::IDX_DEAD_BAND, band[ipdc_pkg::DATA_W-1:0]);
      send_sample(16'sd1500);
      s = smooth_error(-16'sd1500);
      band = ((s < 0) ? -s : s) + 1;
      write_reg(ipdc_pkg::IDX_DEAD_BAND, band[ipdc_pkg::DATA_W-1:0]);
      send_sample(-16'sd1500);
      // top data bit is not part of the band
      write_reg(ipdc_pkg::IDX_DEAD_BAND, TOP_BIT);
      send_sample(16'sd1);
      write_reg(ipdc_pkg::IDX_DEAD_BAND, '1);
      send_sample(16'sh7FFF);
      write_reg(ipdc_pkg::IDX_DEAD_BAND, '0);
      send_sample(-16'sd1);
   endtask

   task automatic test_gain_extremes();
      write_reg(ipdc_pkg::IDX_PROP_GAIN, GAIN_MAX);
      write_reg(ipdc_pkg::IDX_INTEG_GAIN, GAIN_MIN);
      write_reg(ipdc_pkg::IDX_DERIV_GAIN, GAIN_MAX);
      write_reg(ipdc_pkg::IDX_OUT_LIMIT, '1);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
      send_sample(16'sd0);
      // a zero limit pins the drive at zero
      write_reg(ipdc_pkg::IDX_OUT_LIMIT, '0);
      send_sample(16'sh8000);
      send_sample(16'sd512);
   endtask

   task automatic test_limit_lowered();
      write_reg(ipdc_pkg::IDX_PROP_GAIN, 16'd256);
      write_reg(ipdc_pkg::IDX_INTEG_GAIN, 16'd256);
      write_reg(ipdc_pkg::IDX_DERIV_GAIN, '0);
      write_reg(ipdc_pkg::IDX_OUT_LIMIT, FIELD_MAX);
      send_sample(16'sd8000);
      send_sample(16'sd8000);
      // held drive now above the new limit, clamped on the next word
      write_reg(ipdc_pkg::IDX_OUT_LIMIT, 16'd100);
      send_sample(16'sd0);
      send_sample(16'sd0);
   endtask

   task automatic test_unmapped_index();
      logic [ipdc_pkg::CSR_IDX_W-1:0] idx;
      idx = IDX_FIRST_UNMAPPED;
      forever begin
         write_reg(idx, ipdc_pkg::DATA_W'($urandom()));
         if (idx == IDX_LAST_UNMAPPED) break;
         idx = idx + 1'b1;
      end
      send_sample(16'sd3000);
      send_sample(-16'sd3000);
   endtask

   task automatic test_random_phases();
      cfg_mode_type modes[8];
      modes = '{CFG_FLOOR, CFG_CEILING, CFG_TYPICAL, CFG_ANY,
                CFG_TYPICAL, CFG_TYPICAL, CFG_ANY, CFG_TYPICAL};
      foreach (modes[p]) begin
         program_phase(modes[p]);
         repeat (PHASE_WORDS) send_sample(next_sample());
      end
   endtask

   task automatic test_back_pressure();
      program_phase(CFG_TYPICAL);
      // receiver holds off while words keep coming, input must stall
      stall_request = STALL_CYCLES;
      repeat (20) send_sample(next_sample());
   endtask

   task automatic test_no_idle();
      program_phase(CFG_TYPICAL);
      steady = 1'b1;
      repeat (60) send_sample(next_sample());
      steady = 1'b0;
   endtask

   // result side: ready pattern and drive word check
   initial begin
      drive_word_type exp_word;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (drive_expect_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display("unexpected drive word: drive %0d clamped %0b",
                           rsp_drive, rsp_clamped);
            end else begin
               exp_word = drive_expect_q.pop_front();
               if (rsp_drive !== exp_word.drive || rsp_clamped !== exp_word.clamped) begin
                  fail_count++;
                  if (fail_count <= MAX_SHOWN)
                     $display("drive word mismatch: expected %0d/%0b, got %0d/%0b",
                              exp_word.drive, exp_word.clamped, rsp_drive, rsp_clamped);
               end
            end
         end
         if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   initial begin
      ctl_cfg.prop_gain = ipdc_pkg::RST_PROP_GAIN;
      ctl_cfg.integ_gain = ipdc_pkg::RST_INTEG_GAIN;
      ctl_cfg.deriv_gain = ipdc_pkg::RST_DERIV_GAIN;
      ctl_cfg.dead_band = ipdc_pkg::RST_DEAD_BAND;
      ctl_cfg.out_limit = ipdc_pkg::RST_OUT_LIMIT;
      held_err = '0;
      held_inc = '0;
      held_drv = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_defaults();
      test_dead_band_edge();
      test_gain_extremes();
      test_limit_lowered();
      test_unmapped_index();
      test_random_phases();
      test_back_pressure();
      test_no_idle();

      drain_results();
      if (fail_count == 0 && drive_expect_q.size() == 0) begin
         $display("incremental_pid_deadband_clamp_top regression: pass");
      end else begin
         $display("incremental_pid_deadband_clamp_top regression: fail");
      end
      $finish;
   end

endmodule

// File: incremental_pid_deadband_clamp_top.f
+incdir+rtl
rtl/ipdc_pkg.sv
rtl/ipdc_csr.sv
rtl/ipdc_mul.sv
rtl/incremental_pid_deadband_clamp_top.sv
rtl/ipdc_chk.sv
test/tb.sv
